/* rtl/lta_pkg.sv */
package lta_pkg;

  localparam int LenW   = 8;
  localparam int OutW   = 26;
  localparam int NumW   = 33;
  localparam int DivW   = 12;
  localparam int QW     = 19;
  localparam int RecipW = 14;
  localparam int RecipSh = 18;
  localparam int DivStages = NumW;

  // Register indexes
  localparam logic [2:0] RegSf   = 3'd0;
  localparam logic [2:0] RegBw   = 3'd1;
  localparam logic [2:0] RegHdr  = 3'd2;
  localparam logic [2:0] RegCrc  = 3'd3;
  localparam logic [2:0] RegCr   = 3'd4;
  localparam logic [2:0] RegPre  = 3'd5;

  typedef struct packed {
    logic [3:0]  sf;
    logic [8:0]  bw;
    logic        explicit_header;
    logic        crc_enable;
    logic [2:0]  cr;
    logic [15:0] preamble;
  } cfg_t;

  typedef struct packed {
    logic [NumW-1:0] num;
    logic [DivW-1:0] den;
  } div_req_t;

  // ceil(2^18 / (4*sf)) for the clamped spreading factor
  function automatic logic [RecipW-1:0] recip(input logic [3:0] sf);
    logic [RecipW-1:0] r;
    begin
      case (sf)
        4'd5:    r = 14'd13108;
        4'd6:    r = 14'd10923;
        4'd7:    r = 14'd9363;
        4'd8:    r = 14'd8192;
        4'd9:    r = 14'd7282;
        4'd10:   r = 14'd6554;
        4'd11:   r = 14'd5958;
        default: r = 14'd5462;
      endcase
      return r;
    end
  endfunction

endpackage

/* rtl/lora_time_on_air.sv */
// Channel   Role    Payload
// s_axis    in      tdata[7:0] payload_length
// m_axis    out     tdata[25:0] airtime_ms
// apb       config  regs at 4*i: sf, bw, header, crc, cr, preamble
//
// One length enters per cycle while m_axis keeps up: four arithmetic
// stages, then a 33-stage restoring divider giving one quotient bit per stage.
// Reset (rst, synchronous) empties the pipeline and restores register defaults.
// Each stage moves on when it is empty or its successor takes its data, so a
// stall on m_axis fills bubbles before holding s_axis.
module lora_time_on_air import lta_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] payload_length
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [25:0] airtime_ms, [31:26] zero
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t            cfg;
  logic            mid_valid;
  logic            mid_ready;
  div_req_t        mid_req;
  logic [OutW-1:0] quot;

  lta_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  lta_front u_front (
    .clk, .rst, .cfg,
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .len       (s_tdata[LenW-1:0]),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .out_req   (mid_req)
  );

  lta_div u_div (
    .clk, .rst,
    .in_valid  (mid_valid),
    .in_ready  (mid_ready),
    .in_req    (mid_req),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .quot      (quot)
  );

  assign m_tdata = {{(32-OutW){1'b0}}, quot};

endmodule

/* rtl/lta_cfg.sv */
module lta_cfg import lta_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  // Write registers on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sf              <= 4'd7;
      cfg.bw              <= 9'd125;
      cfg.explicit_header <= 1'b1;
      cfg.crc_enable      <= 1'b1;
      cfg.cr              <= 3'd1;
      cfg.preamble        <= 16'd8;
    end else if (wr) begin
      case (idx)
        RegSf:   cfg.sf              <= pwdata[3:0];
        RegBw:   cfg.bw              <= pwdata[8:0];
        RegHdr:  cfg.explicit_header <= pwdata[0];
        RegCrc:  cfg.crc_enable      <= pwdata[0];
        RegCr:   cfg.cr              <= pwdata[2:0];
        RegPre:  cfg.preamble        <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (idx)
      RegSf:   prdata = {28'd0, cfg.sf};
      RegBw:   prdata = {23'd0, cfg.bw};
      RegHdr:  prdata = {31'd0, cfg.explicit_header};
      RegCrc:  prdata = {31'd0, cfg.crc_enable};
      RegCr:   prdata = {29'd0, cfg.cr};
      RegPre:  prdata = {16'd0, cfg.preamble};
      default: prdata = 32'd0;
    endcase
  end

endmodule

/* rtl/lta_front.sv */
module lta_front import lta_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  cfg_t            cfg,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [LenW-1:0] len,
  output logic            out_valid,
  input  logic            out_ready,
  output div_req_t        out_req
);

  logic [3:0] vld;
  logic [3:0] en;

  // Stage 1: clamped config and block numerator
  logic [3:0]  s1_sf;
  logic [8:0]  s1_bw;
  logic [2:0]  s1_cr;
  logic [15:0] s1_pre;
  logic [11:0] s1_n;
  // Stage 2: block count
  logic [3:0]  s2_sf;
  logic [8:0]  s2_bw;
  logic [2:0]  s2_cr;
  logic [15:0] s2_pre;
  logic [6:0]  s2_blk;
  // Stage 3: quarter-symbol total
  logic [3:0]  s3_sf;
  logic [8:0]  s3_bw;
  logic [QW-1:0] s3_q;

  logic [3:0]  sf_c;
  logic [8:0]  bw_c;
  logic [2:0]  cr_c;
  logic [11:0] n_c;
  logic [RecipW+11:0] prod;
  logic [10:0] syms;
  logic [NumW-1:0] shq;

  // Per-stage ready chain
  assign en[3] = !vld[3] || out_ready;
  assign en[2] = !vld[2] || en[3];
  assign en[1] = !vld[1] || en[2];
  assign en[0] = !vld[0] || en[1];
  assign in_ready  = en[0];
  assign out_valid = vld[3];

  always_comb begin
    sf_c = (cfg.sf < 4'd5) ? 4'd5 : ((cfg.sf > 4'd12) ? 4'd12 : cfg.sf);
    bw_c = (cfg.bw < 9'd7) ? 9'd7 : ((cfg.bw > 9'd500) ? 9'd500 : cfg.bw);
    cr_c = (cfg.cr < 3'd1) ? 3'd1 : ((cfg.cr > 3'd4) ? 3'd4 : cfg.cr);
    // a + 4*sf - 1, never negative
    n_c  = {1'b0, len, 3'd0} + 12'd27 + (cfg.crc_enable ? 12'd16 : 12'd0)
           - (cfg.explicit_header ? 12'd0 : 12'd20);
    prod = s1_n * recip(s1_sf);
    syms = s2_blk * ({1'b0, s2_cr} + 4'd4);
    shq  = {{(NumW-QW-1){1'b0}}, s3_q, 1'b0} << s3_sf;
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 4'd0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      if (en[1]) vld[1] <= vld[0];
      if (en[2]) vld[2] <= vld[1];
      if (en[3]) vld[3] <= vld[2];
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_sf  <= sf_c;
      s1_bw  <= bw_c;
      s1_cr  <= cr_c;
      s1_pre <= cfg.preamble;
      s1_n   <= n_c;
    end
    if (en[1]) begin
      s2_sf  <= s1_sf;
      s2_bw  <= s1_bw;
      s2_cr  <= s1_cr;
      s2_pre <= s1_pre;
      s2_blk <= prod[RecipSh+6:RecipSh];
    end
    if (en[2]) begin
      s3_sf <= s2_sf;
      s3_bw <= s2_bw;
      s3_q  <= {1'b0, s2_pre, 2'd0} + QW'(49) + {6'd0, syms, 2'd0};
    end
    if (en[3]) begin
      out_req.num <= shq + {{(NumW-11){1'b0}}, s3_bw, 2'd0};
      out_req.den <= {s3_bw, 3'd0};
    end
  end

endmodule

/* rtl/lta_div.sv */
module lta_div import lta_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  div_req_t        in_req,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [OutW-1:0] quot
);

  logic [DivStages-1:0] vld;
  logic [DivStages-1:0] en;
  logic [NumW-1:0] num [DivStages];
  logic [NumW-1:0] q   [DivStages];
  logic [DivW-1:0] rem [DivStages];
  logic [DivW-1:0] den [DivStages];

  logic [NumW-1:0] num_in [DivStages];
  logic [NumW-1:0] q_in   [DivStages];
  logic [DivW-1:0] rem_in [DivStages];
  logic [DivW-1:0] den_in [DivStages];
  logic [NumW-1:0] num_n  [DivStages];
  logic [NumW-1:0] q_n    [DivStages];
  logic [DivW-1:0] rem_n  [DivStages];
  logic [DivW:0]   trial  [DivStages];

  // Ready chain from the output back
  always_comb begin
    en[DivStages-1] = !vld[DivStages-1] || out_ready;
    for (int k = DivStages-2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[DivStages-1];
  assign quot      = q[DivStages-1][OutW-1:0];

  // One quotient bit per stage, restoring
  always_comb begin
    for (int k = 0; k < DivStages; k++) begin
      if (k == 0) begin
        num_in[k] = in_req.num;
        q_in[k]   = '0;
        rem_in[k] = '0;
        den_in[k] = in_req.den;
      end else begin
        num_in[k] = num[k-1];
        q_in[k]   = q[k-1];
        rem_in[k] = rem[k-1];
        den_in[k] = den[k-1];
      end
      trial[k] = {rem_in[k], num_in[k][NumW-1]};
      num_n[k] = {num_in[k][NumW-2:0], 1'b0};
      if (trial[k] >= {1'b0, den_in[k]}) begin
        rem_n[k] = DivW'(trial[k] - {1'b0, den_in[k]});
        q_n[k]   = {q_in[k][NumW-2:0], 1'b1};
      end else begin
        rem_n[k] = trial[k][DivW-1:0];
        q_n[k]   = {q_in[k][NumW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < DivStages; k++) begin
        if (en[k]) vld[k] <= (k == 0) ? in_valid : vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DivStages; k++) begin
      if (en[k]) begin
        num[k] <= num_n[k];
        q[k]   <= q_n[k];
        rem[k] <= rem_n[k];
        den[k] <= den_in[k];
      end
    end
  end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps

module tb;
  import lta_pkg::*;

  localparam int Latency    = 37;
  localparam int IdleLimit  = 20000;
  localparam int HoldCycles = 400;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;    // [7:0] payload_length
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;         // [25:0] airtime_ms, [31:26] zero
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  lora_time_on_air i_dut (.*);

  always #4 clk = ~clk;

  // Local copy of the register file
  logic [3:0]  cfg_sf;
  logic [8:0]  cfg_bw;
  logic        cfg_hdr;
  logic        cfg_crc;
  logic [2:0]  cfg_cr;
  logic [15:0] cfg_pre;

  logic [7:0]  pending_lengths[$];
  logic [25:0] expected_airtimes[$];
  int          errors = 0;
  int          results_seen = 0;
  int          idle_cycles = 0;
  bit          send_paused = 1'b0;
  bit          hold_sink = 1'b0;
  bit          hold_done = 1'b0;
  int          hold_count = 0;
  int          send_gap = 0;
  int          sink_gap = 0;

  // Time on air in ms for one payload length under the current registers
  function automatic logic [25:0] airtime_for(input logic [7:0] len);
    longint sf, bw, cr, a, den, syms, q, num;
    sf = cfg_sf < 5 ? 5 : (cfg_sf > 12 ? 12 : cfg_sf);
    bw = cfg_bw < 7 ? 7 : (cfg_bw > 500 ? 500 : cfg_bw);
    cr = cfg_cr < 1 ? 1 : (cfg_cr > 4 ? 4 : cfg_cr);
    a = 8 * longint'(len) - 4 * sf + 28;
    if (cfg_crc) a += 16;
    if (!cfg_hdr) a -= 20;
    den = 4 * sf;
    syms = 8;
    if (a > 0) syms += ((a + den - 1) / den) * (cr + 4);
    q = 4 * longint'(cfg_pre) + 17 + 4 * syms;
    num = ((2 * q) << sf) + 4 * bw;
    return 26'(num / (8 * bw));
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Driver: offer queued lengths, predict on acceptance
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_airtimes.push_back(airtime_for(s_tdata));
        void'(pending_lengths.pop_front());
      end
      if (s_tvalid && !s_tready) begin
        // hold the offered transaction
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_tvalid <= 1'b0;
      end else if (!send_paused && pending_lengths.size() > 0) begin
        s_tvalid <= 1'b1;
        s_tdata  <= pending_lengths[0];
        if (s_tvalid && s_tready) send_gap <= pick_gap();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: check each result against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen <= results_seen + 1;
        if (expected_airtimes.size() == 0) begin
          $error("unexpected airtime_ms result %0d", m_tdata[25:0]);
          errors++;
        end else begin
          logic [25:0] exp_t;
          exp_t = expected_airtimes.pop_front();
          if (m_tdata[25:0] !== exp_t) begin
            $error("airtime_ms mismatch: expected %0d actual %0d", exp_t, m_tdata[25:0]);
            errors++;
          end
          if (m_tdata[31:26] !== 6'd0) begin
            $error("pad bits mismatch: expected 0 actual %0h", m_tdata[31:26]);
            errors++;
          end
        end
      end
      // hold off for a counted stretch once requested
      if (hold_sink && !hold_done) begin
        m_tready <= 1'b0;
        hold_count <= hold_count + 1;
        if (hold_count == HoldCycles - 1) hold_done <= 1'b1;
      end else if (sink_gap > 0) begin
        sink_gap <= sink_gap - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (m_tvalid && m_tready) sink_gap <= pick_gap();
      end
    end
  end

  // Watchdog: count cycles with no transaction on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("watchdog expired, %0d results outstanding", expected_airtimes.size());
      $display("** lora_time_on_air: FAILED **");
      $finish;
    end
  end

  task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      RegSf:  cfg_sf  = value[3:0];
      RegBw:  cfg_bw  = value[8:0];
      RegHdr: cfg_hdr = value[0];
      RegCrc: cfg_crc = value[0];
      RegCr:  cfg_cr  = value[2:0];
      RegPre: cfg_pre = value[15:0];
      default: ;
    endcase
  endtask

  task automatic set_all(input logic [3:0] sf, input logic [8:0] bw, input logic hdr,
                         input logic crc, input logic [2:0] cr, input logic [15:0] pre);
    apb_write(RegSf, {28'd0, sf});
    apb_write(RegBw, {23'd0, bw});
    apb_write(RegHdr, {31'd0, hdr});
    apb_write(RegCrc, {31'd0, crc});
    apb_write(RegCr, {29'd0, cr});
    apb_write(RegPre, {16'd0, pre});
  endtask

  // Let the pipeline drain fully before touching registers
  task automatic drain();
    wait (pending_lengths.size() == 0 && !s_tvalid && expected_airtimes.size() == 0);
    repeat (Latency + 4) @(posedge clk);
  endtask

  task automatic random_setting();
    int r;
    r = $urandom_range(0, 3);
    set_all(4'($urandom_range(0, 15)),
            r == 0 ? 9'($urandom_range(0, 511)) : 9'($urandom_range(7, 500)),
            1'($urandom), 1'($urandom), 3'($urandom_range(0, 7)),
            r == 1 ? 16'($urandom) : 16'($urandom_range(0, 64)));
  endtask

  initial begin
    cfg_sf = 4'd7; cfg_bw = 9'd125; cfg_hdr = 1'b1;
    cfg_crc = 1'b1; cfg_cr = 3'd1; cfg_pre = 16'd8;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset values, then extremes and clamped register values
    pending_lengths = '{8'd0, 8'd1, 8'd255, 8'd128, 8'd127, 8'd13};
    drain();
    set_all(4'd5, 9'd500, 1'b0, 1'b0, 3'd1, 16'd0);    // small numerator case
    pending_lengths = '{8'd0, 8'd1, 8'd2, 8'd255};
    drain();
    set_all(4'd12, 9'd7, 1'b1, 1'b1, 3'd4, 16'hFFFF);
    pending_lengths = '{8'd0, 8'd255, 8'd170, 8'd85};
    drain();
    set_all(4'd0, 9'd0, 1'b0, 1'b1, 3'd0, 16'd1);        // below-range clamps
    pending_lengths = '{8'd0, 8'd255, 8'd40};
    drain();
    set_all(4'd15, 9'd511, 1'b1, 1'b0, 3'd7, 16'd12);    // above-range clamps
    pending_lengths = '{8'd0, 8'd255, 8'd40};
    drain();
    apb_write(3'd6, 32'hFFFF_FFFF);                      // unmapped index
    apb_write(3'd7, 32'd0);

    // Random phases, each under a fresh setting
    for (int phase = 0; phase < 10; phase++) begin
      random_setting();
      for (int k = 0; k < 55; k++) pending_lengths.push_back(8'($urandom));
      if (phase == 3) begin
        // stall the sink long enough to back up the pipeline into s_axis
        hold_sink = 1'b1;
        wait (hold_done);
        hold_sink = 1'b0;
      end
      if (phase == 6) begin
        wait (pending_lengths.size() < 25);
        send_paused = 1'b1;
        wait (!s_tvalid && expected_airtimes.size() == 0);
        send_paused = 1'b0;
      end
      drain();
    end

    $display("covered %0d results over directed extremes and 10 random register settings",
             results_seen);
    $display("including clamped register values, a long sink stall and a sender pause");
    if (errors == 0) begin
      $display("** lora_time_on_air: PASSED **");
    end else begin
      $display("** lora_time_on_air: FAILED **");
    end
    $finish;
  end

endmodule
